/* rtl/core/b64pac_pkg.sv */
// Shared types, constants and a character lookup function for the permuted-alphabet Base64 codec.
// No dependencies; every other file in rtl/core imports this package.
package b64pac_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
	localparam int         CMDQ_DEPTH = 4;
	localparam int         CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [7:0] ALPHABET [64] = '{
		"Q", "R", "S", "T", "U", ":", "W", "X", "Y", "Z", "a", "b", "c", "d", "e", "f",
		"A", "B", "C", "D", "E", "F", "G", "H", "I", "J", ";", "L", "M", "N", "O", "P",
		"g", "h", "i", "j", "k", "l", "m", "n", "o", "p", "q", "r", "s", "t", "u", "v",
		"w", "x", "y", "z", "0", "1", "2", ",", "4", "5", "6", "7", "8", "9", "+", "-"
	};

	typedef struct packed {
		logic [7:0] data_in;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
		logic       error;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_ENC = 2'd0,
		CMD_DEC = 2'd1,
		CMD_ERR = 2'd2
	} cmd_kind_t;

	// One finished group, handed from the front to the back.
	// cnt: encode = bytes held (1..3), decode = bytes to emit (1..3).
	typedef struct packed {
		cmd_kind_t   kind;
		logic [23:0] bits;
		logic [1:0]  cnt;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic       is_pad;
		logic       is_bad;
		logic [5:0] code;
	} char_info_t;

	function automatic char_info_t char_lookup(input logic [7:0] ch);
		char_info_t info;
		info.is_pad = (ch == PAD_CHAR);
		info.is_bad = !info.is_pad;
		info.code   = '0;
		for (int k = 0; k < 64; k++) begin
			if (ALPHABET[k] == ch) begin
				info.is_bad = 1'b0;
				info.code   = 6'(k);
			end
		end
		return info;
	endfunction

endpackage

/* rtl/core/base64_permuted_alphabet_codec.sv */
// Flow: a group's command is queued, then taken by the back end once that is free.
// Throughput: one input word per cycle while the 4-entry command queue has room; the back end
//   emits one result word per cycle while the reader pops and work is waiting, so encode
//   runs at 4 results per 3 input bytes and the result port sets the sustained rate.
// Reset: asynchronous, clears mode to encode, the partial group, the queue and the back end.
module base64_permuted_alphabet_codec import b64pac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	logic cmd_valid;
	cmd_t cmd;
	logic q_full;
	logic q_nonempty;
	logic q_pop;
	cmd_t q_data;

	assign full = q_full;

	b64pac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.in_item   (in_item),
		.q_full    (q_full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	b64pac_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cmd_valid),
		.wr_data    (cmd),
		.rd_en      (q_pop),
		.rd_data    (q_data),
		.q_full     (q_full),
		.q_nonempty (q_nonempty)
	);

	b64pac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_item   (out_item)
	);

endmodule

/* rtl/core/b64pac_front.sv */
// Front end: takes bytes or characters, collects groups of three or four,
// and pushes one command per finished group. Depends on b64pac_pkg.
module b64pac_front import b64pac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  logic     push,
	input  in_item_t in_item,
	input  logic     q_full,
	output logic     cmd_valid,
	output cmd_t     cmd
);

	logic        mode_q;
	logic [23:0] bits_q;
	logic [1:0]  cnt_q;
	logic [1:0]  pad_q;
	logic        bad_q;

	logic        accept;
	logic [23:0] bits_n;
	logic [1:0]  cnt_n;
	logic [1:0]  pad_n;
	logic        bad_n;
	logic        done;
	logic [23:0] enc_shift;
	logic [23:0] dec_shift;
	char_info_t  info;
	logic [5:0]  dec_val;

	assign accept = push && !q_full;
	assign info   = char_lookup(in_item.data_in);

	always_comb begin
		case (cnt_q)
			2'd0:    enc_shift = {in_item.data_in, 16'h0};
			2'd1:    enc_shift = {8'h0, in_item.data_in, 8'h0};
			default: enc_shift = {16'h0, in_item.data_in};
		endcase
		dec_val = (info.is_pad || info.is_bad) ? 6'd0 : info.code;
		case (cnt_q)
			2'd0:    dec_shift = {dec_val, 18'h0};
			2'd1:    dec_shift = {6'h0, dec_val, 12'h0};
			2'd2:    dec_shift = {12'h0, dec_val, 6'h0};
			default: dec_shift = {18'h0, dec_val};
		endcase
	end

	always_comb begin
		bits_n    = bits_q;
		cnt_n     = cnt_q;
		pad_n     = pad_q;
		bad_n     = bad_q;
		done      = 1'b0;
		cmd_valid = 1'b0;
		cmd.kind  = CMD_ENC;
		cmd.bits  = '0;
		cmd.cnt   = '0;
		cmd.last  = in_item.last_in;
		if (!mode_q) begin
			bits_n   = bits_q | enc_shift;
			cmd.kind = CMD_ENC;
			cmd.bits = bits_n;
			cmd.cnt  = cnt_q + 2'd1;
			if (cnt_q == 2'd2 || in_item.last_in) begin
				done      = 1'b1;
				cmd_valid = accept;
			end else begin
				cnt_n = cnt_q + 2'd1;
			end
		end else begin
			if (info.is_pad) begin
				if (pad_q != 2'd3)
					pad_n = pad_q + 2'd1;
			end else if (info.is_bad) begin
				bad_n = 1'b1;
			end else if (pad_q != 2'd0) begin
				bad_n = 1'b1; // data after a pad
			end
			bits_n   = bits_q | dec_shift;
			cmd.bits = bits_n;
			if (cnt_q != 2'd3) begin
				if (in_item.last_in) begin
					// short final group
					done      = 1'b1;
					cmd_valid = accept;
					cmd.kind  = CMD_ERR;
					cmd.last  = 1'b1;
				end else begin
					cnt_n = cnt_q + 2'd1;
				end
			end else begin
				done      = 1'b1;
				cmd_valid = accept;
				if (bad_n || pad_n == 2'd3) begin
					cmd.kind = CMD_ERR;
				end else begin
					cmd.kind = CMD_DEC;
					cmd.cnt  = 2'd3 - pad_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			bits_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
			bad_q  <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			bits_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			if (done) begin
				bits_q <= '0;
				cnt_q  <= '0;
				pad_q  <= '0;
				bad_q  <= 1'b0;
			end else begin
				bits_q <= bits_n;
				cnt_q  <= cnt_n;
				pad_q  <= pad_n;
				bad_q  <= bad_n;
			end
		end
	end

endmodule

/* rtl/core/b64pac_cmdq.sv */
// Short command queue between front and back; lets each side stall on its own.
// Depends on b64pac_pkg.
module b64pac_cmdq import b64pac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic q_full,
	output logic q_nonempty
);

	cmd_t                entries_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_ptr_q;
	logic [CMDQ_AW-1:0]  rd_ptr_q;
	logic [CMDQ_AW:0]    count_q;

	assign q_full     = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign q_nonempty = (count_q != '0);
	assign rd_data    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			entries_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/b64pac_back.sv */
// Back end: takes one command at a time and emits its words, one per pop.
// Depends on b64pac_pkg (command type, alphabet table).
module b64pac_back import b64pac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_nonempty,
	input  cmd_t      q_data,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] k_q;
	logic [1:0] last_idx;
	logic [5:0] sextet;
	logic [7:0] byte_sel;
	logic       at_end;

	assign empty = !cur_valid_q;

	always_comb begin
		case (cur_q.kind)
			CMD_ENC: last_idx = 2'd3;
			CMD_DEC: last_idx = cur_q.cnt - 2'd1;
			default: last_idx = 2'd0;
		endcase
		case (k_q)
			2'd0:    sextet = cur_q.bits[23:18];
			2'd1:    sextet = cur_q.bits[17:12];
			2'd2:    sextet = cur_q.bits[11:6];
			default: sextet = cur_q.bits[5:0];
		endcase
		case (k_q)
			2'd0:    byte_sel = cur_q.bits[23:16];
			2'd1:    byte_sel = cur_q.bits[15:8];
			default: byte_sel = cur_q.bits[7:0];
		endcase
	end

	assign at_end = (k_q == last_idx);

	always_comb begin
		out_item.last_out = at_end && cur_q.last;
		case (cur_q.kind)
			CMD_ENC: begin
				// positions past the bytes held become pad characters
				out_item.data_out = (k_q <= cur_q.cnt) ? ALPHABET[sextet] : PAD_CHAR;
				out_item.error    = 1'b0;
			end
			CMD_DEC: begin
				out_item.data_out = byte_sel;
				out_item.error    = 1'b0;
			end
			default: begin
				out_item.data_out = 8'h00;
				out_item.error    = 1'b1;
			end
		endcase
	end

	assign q_pop = q_nonempty && (!cur_valid_q || (pop && at_end));

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			k_q         <= '0;
		end else if (pop && cur_valid_q) begin
			if (at_end)
				cur_valid_q <= 1'b0;
			else
				k_q <= k_q + 2'd1;
		end
	end

endmodule

/* rtl/core/b64pac_chk.sv */
// Port-level checker for the codec, attached to the top level by bind.
// Depends on b64pac_pkg and base64_permuted_alphabet_codec.
module b64pac_chk import b64pac_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_we,
	input logic      cfg_wdata,
	input logic      empty,
	input logic      pop,
	input out_item_t out_item
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	// a waiting word holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.error |-> out_item.data_out == 8'h00)
		else $error("error word carries data");

	// encode always yields a printable character and never an error
	a_enc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !mode_q |-> !out_item.error && out_item.data_out != 8'h00)
		else $error("bad word in encode mode");

endmodule

bind base64_permuted_alphabet_codec b64pac_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.empty     (empty),
	.pop       (pop),
	.out_item  (out_item)
);
